### rtl/cubic_bezier_path_subdivider_unit_assert.svh
// Assertion macros used by the subdivider controller RTL.
`ifndef CUBIC_BEZIER_PATH_SUBDIVIDER_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_PATH_SUBDIVIDER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CBPS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define CBPS_ASSERT(lbl, clk, rst_n, prop)
`define CBPS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### rtl/cbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cbps_pkg;

  localparam int COORD_W = 16;
  localparam int N_W     = 6;
  localparam int W_W     = 3 * N_W;       // weights and n^3
  localparam int ACC_W   = COORD_W + W_W + 2;
  localparam int Q_W     = COORD_W;
  localparam int REM_W   = W_W;
  localparam int NPTS    = 4;
  localparam int IDX_W   = 2;
  localparam int CNT_W   = 4;
  localparam logic [N_W-1:0] N_RESET = N_W'(10);
  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(NPTS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(Q_W - 1);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WGT0,
    OP_WGT1,
    OP_MAC,
    OP_DIV_INIT,
    OP_DIV,
    OP_LOAD_CURVE,
    OP_LOAD_RAW
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             store_wr;
    logic             copy_end;    // move segment end point to slot 0
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [N_W-1:0]   j;
    logic [N_W-1:0]   n;
    logic             run_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/cbps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbps_datapath
// Control point store, Bernstein weights, MAC, restoring divider, output reg.
// ----------------------------------------------------------------------------
module cbps_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cbps_pkg::dp_cmd_t                      cmd_i,
  output cbps_pkg::dp_sts_t                      sts_o,
  input  logic signed [cbps_pkg::COORD_W-1:0]    px_i,
  input  logic signed [cbps_pkg::COORD_W-1:0]    py_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [cbps_pkg::COORD_W-1:0]    qx_o,
  output logic signed [cbps_pkg::COORD_W-1:0]    qy_o,
  output logic                                   run_last_o
);
  import cbps_pkg::*;

  logic signed [COORD_W-1:0] sx_q [NPTS];
  logic signed [COORD_W-1:0] sy_q [NPTS];
  logic [2*N_W-1:0] uu_q, jj_q, uj_q, nn_q;
  logic [W_W-1:0]   w_q [NPTS];
  logic [W_W-1:0]   n3_q;
  logic signed [ACC_W-1:0] accx_q, accy_q;
  logic [REM_W-1:0] remx_q, remy_q;
  logic [Q_W-1:0]   quox_q, quoy_q;
  logic             negx_q, negy_q;
  logic             out_valid_q, run_last_q;
  logic signed [COORD_W-1:0] qx_q, qy_q;

  logic [N_W-1:0] u;
  logic [2*N_W-1:0] u_x, j_x, n_x;
  logic [W_W-1:0]   u_w, j_w, n_w;
  logic signed [COORD_W+W_W:0] prodx, prody;
  logic [ACC_W-1:0] magx, magy;
  logic [REM_W:0] r2x, r2y;
  logic gex, gey;
  logic out_free;

  assign u        = cmd_i.n - cmd_i.j;
  assign u_x      = {{N_W{1'b0}}, u};
  assign j_x      = {{N_W{1'b0}}, cmd_i.j};
  assign n_x      = {{N_W{1'b0}}, cmd_i.n};
  assign u_w      = {{(W_W-N_W){1'b0}}, u};
  assign j_w      = {{(W_W-N_W){1'b0}}, cmd_i.j};
  assign n_w      = {{(W_W-N_W){1'b0}}, cmd_i.n};
  assign prodx    = $signed({1'b0, w_q[cmd_i.rd_idx]}) * sx_q[cmd_i.rd_idx];
  assign prody    = $signed({1'b0, w_q[cmd_i.rd_idx]}) * sy_q[cmd_i.rd_idx];
  assign magx     = accx_q[ACC_W-1] ? ACC_W'(-accx_q) : ACC_W'(accx_q);
  assign magy     = accy_q[ACC_W-1] ? ACC_W'(-accy_q) : ACC_W'(accy_q);
  assign r2x      = {remx_q, quox_q[Q_W-1]};
  assign r2y      = {remy_q, quoy_q[Q_W-1]};
  assign gex      = r2x >= {1'b0, n3_q};
  assign gey      = r2y >= {1'b0, n3_q};
  assign out_free = !out_valid_q || out_ready_i;
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      sx_q[cmd_i.wr_idx] <= px_i;
      sy_q[cmd_i.wr_idx] <= py_i;
    end else if (cmd_i.copy_end) begin
      sx_q[0] <= sx_q[NPTS-1];
      sy_q[0] <= sy_q[NPTS-1];
    end
    unique case (cmd_i.op)
      OP_WGT0: begin
        uu_q <= u_x * u_x;
        jj_q <= j_x * j_x;
        uj_q <= u_x * j_x;
        nn_q <= n_x * n_x;
      end
      OP_WGT1: begin
        w_q[0] <= W_W'(uu_q) * u_w;
        w_q[1] <= W_W'(3) * W_W'(uu_q) * j_w;
        w_q[2] <= W_W'(3) * W_W'(uj_q) * j_w;
        w_q[3] <= W_W'(jj_q) * j_w;
        n3_q   <= W_W'(nn_q) * n_w;
      end
      OP_MAC: begin
        // first term restarts the sum
        accx_q <= ((cmd_i.rd_idx == '0) ? ACC_W'(0) : accx_q) + ACC_W'(prodx);
        accy_q <= ((cmd_i.rd_idx == '0) ? ACC_W'(0) : accy_q) + ACC_W'(prody);
      end
      OP_DIV_INIT: begin
        // quotient fits Q_W bits, so the high part is already below n^3
        remx_q <= magx[Q_W +: REM_W];
        remy_q <= magy[Q_W +: REM_W];
        quox_q <= magx[Q_W-1:0];
        quoy_q <= magy[Q_W-1:0];
        negx_q <= accx_q[ACC_W-1];
        negy_q <= accy_q[ACC_W-1];
      end
      OP_DIV: begin
        remx_q <= gex ? REM_W'(r2x - {1'b0, n3_q}) : r2x[REM_W-1:0];
        remy_q <= gey ? REM_W'(r2y - {1'b0, n3_q}) : r2y[REM_W-1:0];
        quox_q <= {quox_q[Q_W-2:0], gex};
        quoy_q <= {quoy_q[Q_W-2:0], gey};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free && (cmd_i.op == OP_LOAD_CURVE || cmd_i.op == OP_LOAD_RAW)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && cmd_i.op == OP_LOAD_CURVE) begin
      qx_q       <= negx_q ? COORD_W'(-quox_q) : COORD_W'(quox_q);
      qy_q       <= negy_q ? COORD_W'(-quoy_q) : COORD_W'(quoy_q);
      run_last_q <= cmd_i.run_last;
    end else if (out_free && cmd_i.op == OP_LOAD_RAW) begin
      qx_q       <= sx_q[cmd_i.rd_idx];
      qy_q       <= sy_q[cmd_i.rd_idx];
      run_last_q <= cmd_i.run_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign qx_o        = qx_q;
  assign qy_o        = qy_q;
  assign run_last_o  = run_last_q;

endmodule

### rtl/cbps_ctrl.sv
`timescale 1ns / 1ps
`include "cubic_bezier_path_subdivider_unit_assert.svh"
// ----------------------------------------------------------------------------
// cbps_ctrl
// Path tracking and per-point sequencing of the subdivider datapath.
// ----------------------------------------------------------------------------
module cbps_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         path_end_i,
  input  logic [cbps_pkg::N_W-1:0]     subdivisions_i,
  input  cbps_pkg::dp_sts_t            sts_i,
  output cbps_pkg::dp_cmd_t            cmd_o
);
  import cbps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_WGT0, S_WGT1, S_MAC, S_DIVI, S_DIV, S_EMIT, S_RAW
  } state_e;

  state_e           state_q;
  logic             started_q, seen_q;
  logic [IDX_W-1:0] pis_q, lim_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N_W-1:0]   j_q, n_q;
  logic             accept;
  logic [IDX_W-1:0] npis;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign npis       = started_q ? pis_q + IDX_W'(1) : '0;

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = OP_NONE;
    cmd_o.j        = j_q;
    cmd_o.n        = n_q;
    cmd_o.rd_idx   = cnt_q[IDX_W-1:0];
    cmd_o.store_wr = accept;
    cmd_o.wr_idx   = npis;
    unique case (state_q)
      S_WGT0: cmd_o.op = OP_WGT0;
      S_WGT1: cmd_o.op = OP_WGT1;
      S_MAC:  cmd_o.op = OP_MAC;
      S_DIVI: cmd_o.op = OP_DIV_INIT;
      S_DIV:  cmd_o.op = OP_DIV;
      S_EMIT: begin
        cmd_o.op       = OP_LOAD_CURVE;
        cmd_o.run_last = (j_q == n_q);
        cmd_o.copy_end = sts_i.out_free && (j_q == n_q);
      end
      S_RAW: begin
        cmd_o.op       = OP_LOAD_RAW;
        cmd_o.run_last = (cnt_q[IDX_W-1:0] == lim_q);
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      seen_q    <= 1'b0;
      pis_q     <= '0;
      lim_q     <= '0;
      cnt_q     <= '0;
      j_q       <= '0;
      n_q       <= N_W'(1);
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            j_q   <= '0;
            n_q   <= (subdivisions_i == '0) ? N_W'(1) : subdivisions_i;
            lim_q <= npis;
            if (path_end_i) begin
              started_q <= 1'b0;
              seen_q    <= 1'b0;
              pis_q     <= '0;
            end else begin
              started_q <= 1'b1;
              seen_q    <= started_q && (seen_q || npis == IDX_W'(NPTS - 1));
              pis_q     <= (npis == IDX_W'(NPTS - 1)) ? '0 : npis;
            end
            if (npis == IDX_W'(NPTS - 1)) begin
              state_q <= S_WGT0;
            end else if (path_end_i && !(started_q && seen_q)) begin
              state_q <= S_RAW;
            end
          end
        end
        S_WGT0: state_q <= S_WGT1;
        S_WGT1: begin
          cnt_q   <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          if (cnt_q == MAC_LAST) begin
            state_q <= S_DIVI;
          end
          cnt_q <= (cnt_q == MAC_LAST) ? '0 : cnt_q + CNT_W'(1);
        end
        S_DIVI: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == DIV_LAST) begin
            state_q <= S_EMIT;
          end
          cnt_q <= cnt_q + CNT_W'(1);
        end
        S_EMIT: begin
          // hold until the output register frees up
          if (sts_i.out_free) begin
            if (j_q == n_q) begin
              state_q <= S_IDLE;
            end else begin
              j_q     <= j_q + N_W'(1);
              state_q <= S_WGT0;
            end
          end
        end
        S_RAW: begin
          if (sts_i.out_free) begin
            if (cnt_q[IDX_W-1:0] == lim_q) begin
              state_q <= S_IDLE;
            end
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `CBPS_ASSERT(a_load_free, clk_i, rst_ni, (state_q == S_EMIT && !sts_i.out_free) |=> (state_q == S_EMIT))
  `CBPS_ASSERT_NEVER(a_j_range, clk_i, rst_ni, j_q > n_q)
  `CBPS_ASSERT(a_end_clears, clk_i, rst_ni, (accept && path_end_i) |=> !started_q)

endmodule

### rtl/cubic_bezier_path_subdivider_unit.sv
`timescale 1ns / 1ps
// Takes a path of control points, one per beat, and emits subdivision points of
// every closed cubic segment. A point that opens a segment or buffers is taken
// while the controller stays idle. A closing point starts N+1 curve points, each
// stepped through the bit-serial datapath (weights, MAC, divide, load); a short
// path emits one point a cycle while the output register is free.
// ----------------------------------------------------------------------------
// cubic_bezier_path_subdivider_unit
// Top level: config register, controller and datapath.
// ----------------------------------------------------------------------------
module cubic_bezier_path_subdivider_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cbps_pkg::N_W-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cbps_pkg::COORD_W-1:0] px_i,
  input  logic signed [cbps_pkg::COORD_W-1:0] py_i,
  input  logic                                path_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cbps_pkg::COORD_W-1:0] qx_o,
  output logic signed [cbps_pkg::COORD_W-1:0] qy_o,
  output logic                                run_last_o
);
  import cbps_pkg::*;

  logic [N_W-1:0] subdiv_q;
  dp_cmd_t        cmd;
  dp_sts_t        sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subdiv_q <= N_RESET;
    end else if (cfg_we_i) begin
      subdiv_q <= cfg_wdata_i;
    end
  end

  cbps_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .path_end_i     (path_end_i),
    .subdivisions_i (subdiv_q),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  cbps_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .px_i        (px_i),
    .py_i        (py_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .qx_o        (qx_o),
    .qy_o        (qy_o),
    .run_last_o  (run_last_o)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives control-point paths into the cubic Bezier subdivider, predicts every
// curve point in integer arithmetic and compares the output beats in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cbps_pkg::*;

  localparam int MAX_CYCLES = 4000000;

  typedef struct {
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic                      last;
  } curve_pt_t;

  typedef struct {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      pend;
    logic                      typed;   // expected point written in the row
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } ctrl_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [N_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [COORD_W-1:0] px_i = '0;
  logic signed [COORD_W-1:0] py_i = '0;
  logic path_end_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [COORD_W-1:0] qx_o;
  logic signed [COORD_W-1:0] qy_o;
  logic run_last_o;

  cubic_bezier_path_subdivider_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .px_i(px_i), .py_i(py_i), .path_end_i(path_end_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .qx_o(qx_o), .qy_o(qy_o), .run_last_o(run_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [N_W-1:0] subdiv_reg;
  longint ctl_x[4];
  longint ctl_y[4];
  int pts_held;
  bit seg_closed;
  bit path_open;

  curve_pt_t pending_pts[$];
  int new_pts = 0;
  curve_pt_t newest_pt;
  int errors = 0;
  int cycles = 0;
  bit rx_stall_on = 1'b1;

  function automatic longint bezier_coord(longint p0, longint p1, longint p2,
                                          longint p3, longint j, longint n);
    longint u;
    u = n - j;
    return (u*u*u*p0 + 3*u*u*j*p1 + 3*u*j*j*p2 + j*j*j*p3) / (n*n*n);
  endfunction

  function automatic void push_pt(longint x, longint y);
    curve_pt_t p;
    p.qx = x[COORD_W-1:0];
    p.qy = y[COORD_W-1:0];
    p.last = 1'b0;
    pending_pts = {pending_pts, p};
  endfunction

  function automatic void predict_point(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y, logic pend);
    int before_cnt;
    longint n;
    before_cnt = pending_pts.size();
    if (!path_open) begin
      ctl_x[0] = x; ctl_y[0] = y;
      pts_held = 0; seg_closed = 0; path_open = 1;
    end else begin
      pts_held = (pts_held + 1) & 3;
      ctl_x[pts_held] = x; ctl_y[pts_held] = y;
      if (pts_held == 3) begin
        n = (subdiv_reg == 0) ? 1 : subdiv_reg;
        for (longint j = 0; j <= n; j++)
          push_pt(bezier_coord(ctl_x[0], ctl_x[1], ctl_x[2], ctl_x[3], j, n),
                  bezier_coord(ctl_y[0], ctl_y[1], ctl_y[2], ctl_y[3], j, n));
        ctl_x[0] = ctl_x[3]; ctl_y[0] = ctl_y[3];
        pts_held = 0; seg_closed = 1;
      end
    end
    if (pend) begin
      if (!seg_closed)
        for (int k = 0; k <= pts_held; k++) push_pt(ctl_x[k], ctl_y[k]);
      path_open = 0; pts_held = 0; seg_closed = 0;
    end
    new_pts = pending_pts.size() - before_cnt;
    if (new_pts > 0) begin
      pending_pts[pending_pts.size()-1].last = 1'b1;
      newest_pt = pending_pts[pending_pts.size()-1];
    end
  endfunction

  // output checker
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected beat qx=%0d qy=%0d", qx_o, qy_o);
        errors++;
      end else begin
        curve_pt_t e;
        e = pending_pts.pop_front();
        if (qx_o !== e.qx) begin
          $error("qx expected %0d actual %0d", e.qx, qx_o); errors++;
        end
        if (qy_o !== e.qy) begin
          $error("qy expected %0d actual %0d", e.qy, qy_o); errors++;
        end
        if (run_last_o !== e.last) begin
          $error("run_last expected %0b actual %0b", e.last, run_last_o); errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (!rx_stall_on) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk_i) begin
    if (cycles >= MAX_CYCLES) begin
      $display("[cubic_bezier_path_subdivider_unit] ERROR");
      $finish;
    end
  end

  task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic pend);
    px_i <= x; py_i <= y; path_end_i <= pend; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_point(x, y, pend);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int lo, int hi);
    int g;
    g = $urandom_range(lo, hi);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pts.size() != 0) @(negedge clk_i);
    // a dropped trailing point may still be in flight
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_subdiv(logic [N_W-1:0] v);
    cfg_wdata_i <= v; cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    subdiv_reg = v;
  endtask

  function automatic logic signed [COORD_W-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return COORD_W'($urandom());
    endcase
  endfunction

  ctrl_row_t dir_rows[$];

  function automatic void add_row(int x, int y, bit pend, bit typed = 0,
                                  int ex = 0, int ey = 0);
    ctrl_row_t r;
    r.px = COORD_W'(x); r.py = COORD_W'(y); r.pend = pend; r.typed = typed;
    r.ex = COORD_W'(ex); r.ey = COORD_W'(ey);
    dir_rows = {dir_rows, r};
  endfunction

  initial begin
    int left;
    int burst;
    int seg_cnt;
    logic [N_W-1:0] n_list[5];
    subdiv_reg = N_RESET;
    foreach (ctl_x[i]) begin ctl_x[i] = 0; ctl_y[i] = 0; end
    pts_held = 0; seg_closed = 0; path_open = 0;

    // single-point path echoes the point; extremes typed in
    add_row(32767, -32768, 1, 1, 32767, -32768);
    add_row(-32768, 32767, 1, 1, -32768, 32767);
    // short paths of two and three points
    add_row(100, -200, 0);
    add_row(-5, 7, 1, 1, -5, 7);
    add_row(1, 2, 0); add_row(3, 4, 0); add_row(-1, -1, 1);
    // segment closes on the end mark
    add_row(32767, 32767, 0); add_row(-32768, -32768, 0);
    add_row(32767, -32768, 0); add_row(-32768, 32767, 1);
    // two segments then trailing points dropped
    add_row(0, 0, 0); add_row(1000, 3000, 0); add_row(-2000, 500, 0);
    add_row(300, -300, 0); add_row(9, 9, 0); add_row(-9, -9, 0);
    add_row(77, 77, 0); add_row(5, 5, 0); add_row(6, 6, 1);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at reset N
    foreach (dir_rows[i]) begin
      send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pend);
      if (dir_rows[i].typed) begin
        if (new_pts == 0) begin
          $error("row %0d expected a beat, none predicted", i); errors++;
        end else begin
          if (newest_pt.qx !== dir_rows[i].ex) begin
            $error("qx expected %0d actual %0d", dir_rows[i].ex, newest_pt.qx); errors++;
          end
          if (newest_pt.qy !== dir_rows[i].ey) begin
            $error("qy expected %0d actual %0d", dir_rows[i].ey, newest_pt.qy); errors++;
          end
        end
      end
    end
    drain();

    // zero, one, extreme and random subdivision settings
    n_list[0] = 0; n_list[1] = 1; n_list[2] = 63;
    n_list[3] = N_W'($urandom_range(2, 8));
    n_list[4] = N_W'($urandom_range(2, 12));
    for (int ph = 0; ph < 5; ph++) begin
      write_subdiv(n_list[ph]);
      rx_stall_on = (ph != 2);
      left = (ph == 2) ? 12 : 30;
      while (left > 0) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: short or broken path
          burst = $urandom_range(1, 5);
          for (int k = 0; k < burst && left > 0; k++, left--)
            send_point(rnd_coord(), rnd_coord(), (k == burst-1));
        end else begin
          // well-formed path of one to three segments, maybe trailing points
          seg_cnt = $urandom_range(1, 3);
          burst = 1 + 3*seg_cnt + $urandom_range(0, 1);
          for (int k = 0; k < burst; k++, left--) begin
            send_point(rnd_coord(), rnd_coord(), (k == burst-1));
            if ($urandom_range(0, 3) == 0) idle_gap(1, 6);
          end
        end
        if ($urandom_range(0, 2) == 0) idle_gap(0, 10);
        if (ph == 3 && left < 20 && left > 15) drain();
      end
      drain();
    end

    if (errors == 0)
      $display("[cubic_bezier_path_subdivider_unit] OK");
    else
      $display("[cubic_bezier_path_subdivider_unit] ERROR");
    $finish;
  end
endmodule
